[rtl/core/image_rotation_remapper_defines.svh]
// Assertion macros used by the checker of the image rotation remapper.
`ifndef IMAGE_ROTATION_REMAPPER_DEFINES_SVH
`define IMAGE_ROTATION_REMAPPER_DEFINES_SVH

// Property that must hold in the cycle after the antecedent, outside reset.
`define IRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after the antecedent, reset included.
`define IRR_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/irr_pkg.sv]
// Types, constants and trigonometry table builder for the image rotation remapper.
package irr_pkg;

  // Configuration register map, one 32-bit register every four bytes.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ANGLE        = 2'd2,
    REG_FILL         = 2'd3
  } cfg_reg_t;

  // Request codes on the input channel.
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  // Register widths and reset values.
  localparam int unsigned DIM_REG_W   = 9;
  localparam int unsigned ANGLE_W     = 9;
  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned COORD_W     = 8;
  localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

  // Angle handling.
  localparam int unsigned QUAD_DEG   = 90;
  localparam int unsigned BASE_W     = 7;
  localparam logic [9:0]  DEG_FULL   = 10'd360;
  localparam logic [9:0]  DEG_QUART  = 10'd90;
  localparam logic [8:0]  DEG_QUART9 = 9'd90;
  localparam logic [8:0]  DEG_HALF9  = 9'd180;
  localparam logic [8:0]  DEG_3Q9    = 9'd270;
  localparam logic [8:0]  DEG_FULL9  = 9'd360;

  // Result buffer depth; a power of two.
  localparam int unsigned OUT_FIFO_DEPTH = 8;

  // Pi in unsigned Q2.30 and the Taylor series divisors (2k)(2k+1).
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              neg;
  } fold_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               source_in_range;
  } result_t;

  // Sine of d whole degrees (0..90) in Q30 by a truncating Taylor series.
  function automatic logic [63:0] sin_q30(input int unsigned d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(d) * PI_Q30) / 180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k]);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Sine magnitude of d degrees rounded half up to frac fraction bits.
  function automatic logic [31:0] sin_fixed(input int unsigned d, input int unsigned frac);
    logic [63:0] q;
    q = sin_q30(d);
    q = (q + (64'd1 << (29 - frac))) >> (30 - frac);
    return 32'(q);
  endfunction

  // Reduce a value below 720 to 0..359.
  function automatic logic [8:0] reduce_360(input logic [9:0] v);
    logic [9:0] r;
    r = (v >= DEG_FULL) ? (v - DEG_FULL) : v;
    return r[8:0];
  endfunction

  // Fold an angle of 0..359 onto the first quadrant with a sign.
  function automatic fold_t fold_angle(input logic [8:0] d);
    fold_t f;
    f.neg = 1'b0;
    if (d <= DEG_QUART9) begin
      f.base = BASE_W'(d);
    end else if (d <= DEG_HALF9) begin
      f.base = BASE_W'(DEG_HALF9 - d);
    end else if (d <= DEG_3Q9) begin
      f.base = BASE_W'(d - DEG_HALF9);
      f.neg  = 1'b1;
    end else begin
      f.base = BASE_W'(DEG_FULL9 - d);
      f.neg  = 1'b1;
    end
    return f;
  endfunction

endpackage

[rtl/core/irr_if.sv]
// Handshake interfaces for the input and result channels.
interface irr_in_if;
  import irr_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [PIXEL_W-1:0] pixel_in;

  modport source (output valid, req_type, coord_x, coord_y, pixel_in, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, pixel_in, output ready);
endinterface

interface irr_out_if;
  import irr_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_out;
  logic               source_in_range;

  modport source (output valid, pixel_out, source_in_range, input ready);
  modport sink   (input valid, pixel_out, source_in_range, output ready);
endinterface

[rtl/core/irr_ram.sv]
// Generic single-port RAM with registered read data and no reset.
module irr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: a write, or a read whose data lands next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/core/irr_out_fifo.sv]
// Result buffer that decouples the mapping pipeline from the result channel.
module irr_out_fifo import irr_pkg::*; #(
  parameter int DEPTH = 8,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  result_t          push_data,
  input  logic             pop,
  output result_t          head,
  output logic [CNT_W-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);

  result_t          entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // Pointers and fill count; pointers wrap as the depth is a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign count = count_r;

endmodule

[rtl/core/image_rotation_remapper.sv]
// Top level of the image rotation remapper: registers, mapping pipeline and frame store.
//
// Usage. Words on in_word either load a pixel (req_type 0) into the frame store at
// (coord_x, coord_y) or query an output pixel (req_type 1). A query is mapped back
// to srcx = trunc(c*x + s*y), srcy = trunc(-s*x + c*y) with c and s the cosine and
// sine of angle_degrees, and answered on out_word with the stored pixel, or with
// fill_value and source_in_range low when the source lies outside the image.
// Loads give no result; loads outside the configured image are dropped.
// Throughput is one word per cycle while in_word.ready is high. A query's result passes
// four pipeline stages, then the frame store read, then the result buffer to out_word.
// Loads and query reads meet the frame store in the same stage and in input
// order, so a query always sees every load accepted before it.
// Results wait in an eight-entry buffer; when the receiver stalls, in_word.ready
// falls once buffered plus in-flight queries fill it, and nothing is lost.
// Configuration goes through the APB port; the user must write it only while idle,
// which the block itself does not enforce. Reset restores the register defaults and
// empties the pipeline and buffer; in_word.ready rises in the cycle after reset is
// released. The frame store is not cleared: a pixel must be loaded before it is queried.
module image_rotation_remapper import irr_pkg::*; #(
  parameter int MAX_WIDTH      = 256,
  parameter int MAX_HEIGHT     = 256,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  irr_in_if.sink                in_word,
  irr_out_if.source             out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int TRIG_MAG_W = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
  localparam int OPND_W     = COORD_W + 1;
  localparam int PROD_W     = TRIG_W + OPND_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int Q_W        = SUM_W - TRIG_FRAC_BITS;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_NEED_W = $clog2(MAX_DIM + 1);
  localparam int CMP_A_W    = (Q_W > DIM_NEED_W) ? Q_W : DIM_NEED_W;
  localparam int CMP_W      = (CMP_A_W > DIM_REG_W) ? CMP_A_W : DIM_REG_W;
  localparam int FIFO_CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int OCC_W      = FIFO_CNT_W + 1;

  // ---------------------------------------------------------------- registers
  logic [DIM_REG_W-1:0] width_r, width_nxt;
  logic [DIM_REG_W-1:0] height_r, height_nxt;
  logic [ANGLE_W-1:0]   angle_r, angle_nxt;
  logic [PIXEL_W-1:0]   fill_r, fill_nxt;
  logic                 cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // Register write decode.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    angle_nxt  = angle_r;
    fill_nxt   = fill_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_IMAGE_WIDTH:  width_nxt  = pwdata[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_nxt = pwdata[DIM_REG_W-1:0];
        REG_ANGLE:        angle_nxt  = pwdata[ANGLE_W-1:0];
        REG_FILL:         fill_nxt   = pwdata[PIXEL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      angle_r  <= '0;
      fill_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      angle_r  <= angle_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_r);
      REG_ANGLE:        prdata = CFG_DATA_W'(angle_r);
      REG_FILL:         prdata = CFG_DATA_W'(fill_r);
    endcase
  end

  // Effective image size: zero acts as one, oversize clamps to the maximum.
  logic [CMP_W-1:0] eff_w;
  logic [CMP_W-1:0] eff_h;

  always_comb begin
    if (width_r == '0) begin
      eff_w = CMP_W'(1);
    end else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = CMP_W'(width_r);
    end
    if (height_r == '0) begin
      eff_h = CMP_W'(1);
    end else if (CMP_W'(height_r) > CMP_W'(MAX_HEIGHT)) begin
      eff_h = CMP_W'(MAX_HEIGHT);
    end else begin
      eff_h = CMP_W'(height_r);
    end
  end

  // ------------------------------------------------------------- trig table
  // Quarter-wave sine magnitudes, built at elaboration.
  logic [TRIG_MAG_W-1:0] sin_rom [QUAD_DEG+1];

  for (genvar g = 0; g <= QUAD_DEG; g++) begin : g_sin_rom
    assign sin_rom[g] = TRIG_MAG_W'(sin_fixed(g, TRIG_FRAC_BITS));
  end

  logic [8:0]              sin_deg;
  logic [8:0]              cos_deg;
  fold_t                   sin_fold;
  fold_t                   cos_fold;
  logic signed [TRIG_W-1:0] sin_val;
  logic signed [TRIG_W-1:0] cos_val;
  logic signed [TRIG_W-1:0] sin_r;
  logic signed [TRIG_W-1:0] cos_r;

  // Sine and cosine of the configured angle, refreshed every cycle.
  always_comb begin
    sin_deg  = reduce_360(10'(angle_r));
    cos_deg  = reduce_360(10'(sin_deg) + DEG_QUART);
    sin_fold = fold_angle(sin_deg);
    cos_fold = fold_angle(cos_deg);
    sin_val  = sin_fold.neg ? -TRIG_W'(sin_rom[sin_fold.base])
                            :  TRIG_W'(sin_rom[sin_fold.base]);
    cos_val  = cos_fold.neg ? -TRIG_W'(sin_rom[cos_fold.base])
                            :  TRIG_W'(sin_rom[cos_fold.base]);
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_val;
    cos_r <= cos_val;
  end

  // --------------------------------------------------------------- pipeline
  logic                 run_r;
  logic                 accept;
  logic                 s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  req_t                 s1_req_r, s2_req_r, s3_req_r, s4_req_r;
  logic [COORD_W-1:0]   s1_x_r, s2_x_r, s3_x_r, s4_x_r;
  logic [COORD_W-1:0]   s1_y_r, s2_y_r, s3_y_r, s4_y_r;
  logic [PIXEL_W-1:0]   s1_pix_r, s2_pix_r, s3_pix_r, s4_pix_r;
  logic signed [PROD_W-1:0] s2_cx_r, s2_sy_r, s2_sx_r, s2_cy_r;
  logic signed [SUM_W-1:0]  s3_sumx_r, s3_sumy_r;
  logic [SUM_W-1:0]     magx, magy;
  logic [Q_W-1:0]       s4_qx_r, s4_qy_r;
  logic                 s4_negx_r, s4_negy_r;
  logic                 s5_in_range_r;

  assign accept = in_word.valid && in_word.ready;

  // Valid bits of each stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      run_r    <= 1'b1;
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r && (s4_req_r == REQ_QUERY);
    end
  end

  // Stage 1 captures the word; stage 2 forms the four products.
  always_ff @(posedge clk) begin
    s1_req_r <= req_t'(in_word.req_type);
    s1_x_r   <= in_word.coord_x;
    s1_y_r   <= in_word.coord_y;
    s1_pix_r <= in_word.pixel_in;

    s2_req_r <= s1_req_r;
    s2_x_r   <= s1_x_r;
    s2_y_r   <= s1_y_r;
    s2_pix_r <= s1_pix_r;
    s2_cx_r  <= PROD_W'(cos_r) * PROD_W'($signed({1'b0, s1_x_r}));
    s2_sy_r  <= PROD_W'(sin_r) * PROD_W'($signed({1'b0, s1_y_r}));
    s2_sx_r  <= PROD_W'(sin_r) * PROD_W'($signed({1'b0, s1_x_r}));
    s2_cy_r  <= PROD_W'(cos_r) * PROD_W'($signed({1'b0, s1_y_r}));
  end

  // Stage 3 sums the products into source coordinates in fixed point.
  always_ff @(posedge clk) begin
    s3_req_r  <= s2_req_r;
    s3_x_r    <= s2_x_r;
    s3_y_r    <= s2_y_r;
    s3_pix_r  <= s2_pix_r;
    s3_sumx_r <= SUM_W'(s2_cx_r) + SUM_W'(s2_sy_r);
    s3_sumy_r <= SUM_W'(s2_cy_r) - SUM_W'(s2_sx_r);
  end

  // Stage 4 truncates toward zero: drop the fraction of the magnitude.
  always_comb begin
    magx = s3_sumx_r[SUM_W-1] ? SUM_W'(-s3_sumx_r) : SUM_W'(s3_sumx_r);
    magy = s3_sumy_r[SUM_W-1] ? SUM_W'(-s3_sumy_r) : SUM_W'(s3_sumy_r);
  end

  always_ff @(posedge clk) begin
    s4_req_r  <= s3_req_r;
    s4_x_r    <= s3_x_r;
    s4_y_r    <= s3_y_r;
    s4_pix_r  <= s3_pix_r;
    s4_qx_r   <= Q_W'(magx >> TRIG_FRAC_BITS);
    s4_qy_r   <= Q_W'(magy >> TRIG_FRAC_BITS);
    s4_negx_r <= s3_sumx_r[SUM_W-1];
    s4_negy_r <= s3_sumy_r[SUM_W-1];
  end

  // Range check and frame store access; a negative value that truncated to zero is zero.
  logic              src_in_range;
  logic              load_in_range;
  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIXEL_W-1:0] ram_rdata;

  always_comb begin
    src_in_range  = (!s4_negx_r || (s4_qx_r == '0)) && (!s4_negy_r || (s4_qy_r == '0))
                    && (CMP_W'(s4_qx_r) < eff_w) && (CMP_W'(s4_qy_r) < eff_h);
    load_in_range = (CMP_W'(s4_x_r) < eff_w) && (CMP_W'(s4_y_r) < eff_h);
    ram_we        = s4_vld_r && (s4_req_r == REQ_LOAD) && load_in_range;
    ram_en        = ram_we || (s4_vld_r && (s4_req_r == REQ_QUERY) && src_in_range);
    if (s4_req_r == REQ_LOAD) begin
      ram_addr = ADDR_W'(s4_y_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(s4_x_r);
    end else begin
      ram_addr = ADDR_W'(s4_qy_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(s4_qx_r);
    end
  end

  irr_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s4_pix_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    s5_in_range_r <= src_in_range;
  end

  // ---------------------------------------------------------- result buffer
  result_t                 push_word;
  result_t                 head_word;
  logic [FIFO_CNT_W-1:0]   fifo_count;
  logic                    pop;
  logic [OCC_W-1:0]        occupancy;

  always_comb begin
    push_word.pixel_out       = s5_in_range_r ? ram_rdata : fill_r;
    push_word.source_in_range = s5_in_range_r;
  end

  assign pop = out_word.valid && out_word.ready;

  irr_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s5_vld_r),
    .push_data (push_word),
    .pop       (pop),
    .head      (head_word),
    .count     (fifo_count)
  );

  // Queries in flight plus buffered results must leave room for one more.
  always_comb begin
    occupancy = OCC_W'(fifo_count)
              + OCC_W'(s1_vld_r && (s1_req_r == REQ_QUERY))
              + OCC_W'(s2_vld_r && (s2_req_r == REQ_QUERY))
              + OCC_W'(s3_vld_r && (s3_req_r == REQ_QUERY))
              + OCC_W'(s4_vld_r && (s4_req_r == REQ_QUERY))
              + OCC_W'(s5_vld_r);
  end

  assign in_word.ready            = run_r && (occupancy < OCC_W'(OUT_FIFO_DEPTH));
  assign out_word.valid           = (fifo_count != '0);
  assign out_word.pixel_out       = head_word.pixel_out;
  assign out_word.source_in_range = head_word.source_in_range;

endmodule

[rtl/core/irr_checker.sv]
// Port-level checker for the image rotation remapper and its bind statement.
`include "image_rotation_remapper_defines.svh"

module irr_checker import irr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIXEL_W-1:0]    pixel_out,
  input logic                  source_in_range,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic                  pready,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata
);

  logic fill_write;

  assign fill_write = psel && penable && pwrite && pready && (paddr[3:2] == REG_FILL);

  // Reset empties the result buffer.
  `IRR_ASSERT_NEXT_ANY(a_reset_empties, !rst_n, !out_valid, "result shown after reset")

  // A stalled result word stays offered and unchanged.
  `IRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn")
  `IRR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
    $stable(pixel_out) && $stable(source_in_range), "stalled result changed")

  // A fill value write reads back as written, masked to eight bits.
  `IRR_ASSERT_NEXT(a_fill_readback, fill_write,
    (paddr[3:2] != REG_FILL) || (prdata == CFG_DATA_W'($past(pwdata[PIXEL_W-1:0]))),
    "fill value read-back mismatch")

endmodule

bind image_rotation_remapper irr_checker u_irr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_word.valid),
  .out_ready       (out_word.ready),
  .pixel_out       (out_word.pixel_out),
  .source_in_range (out_word.source_in_range),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .pready          (pready),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);

[verif/tb_top.sv]
// Self-checking testbench for the image rotation remapper: predicts every query result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import irr_pkg::*;

  localparam int FRAME_DIM       = 256;
  localparam int Q_FRAC          = 14;
  localparam int PIPE_SETTLE     = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [63:0] PI_Q2_30 = 64'd3373259426;

  // One word on the input channel.
  typedef struct packed {
    req_t               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIXEL_W-1:0] pixel;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  irr_in_if  in_word ();
  irr_out_if out_word ();

  image_rotation_remapper #(
    .MAX_WIDTH      (FRAME_DIM),
    .MAX_HEIGHT     (FRAME_DIM),
    .TRIG_FRAC_BITS (Q_FRAC)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Register copies as the block should see them.
  logic [DIM_REG_W-1:0] cfg_width;
  logic [DIM_REG_W-1:0] cfg_height;
  logic [ANGLE_W-1:0]   cfg_angle;
  logic [PIXEL_W-1:0]   cfg_fill;

  // Sine of each whole degree in signed Q1.14.
  longint sine_q14 [0:359];

  // Predicted frame store contents, and which pixels the stimulus has loaded.
  logic [PIXEL_W-1:0] frame_model  [0:FRAME_DIM*FRAME_DIM-1];
  bit                 pixel_loaded [0:FRAME_DIM*FRAME_DIM-1];

  pixel_word_t pending_words [$];
  result_t     expected_pixels [$];
  pixel_word_t offered_word;
  result_t     oldest_pixel;

  int mismatch_count;
  int src_idle_pct;
  int sink_idle_pct;
  int src_idle_left;
  int sink_idle_left;
  bit stall_request;
  bit stall_seen;
  int stall_left;

  // Clock: 10 ns period.
  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // Sine of 0..90 degrees in Q30 by a truncated Taylor series.
  function automatic longint unsigned taylor_sine_q30(input int unsigned base_deg);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned acc;
    ang    = (64'(base_deg) * PI_Q2_30) / 64'd180;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = ang;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      acc  = (n % 2 == 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  // Signed fixed-point sine of any angle, folded onto the first quadrant.
  function automatic longint signed_sine(input int unsigned deg);
    int unsigned     d;
    int unsigned     base;
    bit              neg;
    longint unsigned mag;
    d   = deg % 360;
    neg = 1'b0;
    if (d <= 90) begin
      base = d;
    end else if (d <= 180) begin
      base = 180 - d;
    end else if (d <= 270) begin
      base = d - 180;
      neg  = 1'b1;
    end else begin
      base = 360 - d;
      neg  = 1'b1;
    end
    mag = (taylor_sine_q30(base) + (64'd1 << (29 - Q_FRAC))) >> (30 - Q_FRAC);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // A dimension register of 0 acts as 1, anything above the frame acts as the frame.
  function automatic int unsigned eff_dim(input logic [DIM_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > FRAME_DIM) return FRAME_DIM;
    return r;
  endfunction

  function automatic int unsigned reduced_angle();
    return cfg_angle % 360;
  endfunction

  // Drop the fraction bits, rounding toward zero.
  function automatic longint trunc_q14(input longint v);
    if (v < 0) return -((-v) >>> Q_FRAC);
    return v >>> Q_FRAC;
  endfunction

  // Inverse mapping of an output coordinate back into the source image.
  function automatic void map_source(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                     output longint sx, output longint sy);
    longint cs;
    longint sn;
    longint xs;
    longint ys;
    sn = sine_q14[reduced_angle()];
    cs = sine_q14[(reduced_angle() + 90) % 360];
    xs = longint'(x);
    ys = longint'(y);
    sx = trunc_q14(cs * xs + sn * ys);
    sy = trunc_q14(-sn * xs + cs * ys);
  endfunction

  function automatic bit source_inside(input longint sx, input longint sy);
    return sx >= 0 && sy >= 0 && sx < eff_dim(cfg_width) && sy < eff_dim(cfg_height);
  endfunction

  // Apply an accepted word to the predicted store, or predict its result.
  task automatic apply_word(input pixel_word_t wd);
    longint  sx;
    longint  sy;
    result_t r;
    if (wd.kind == REQ_LOAD) begin
      if (wd.x < eff_dim(cfg_width) && wd.y < eff_dim(cfg_height)) begin
        frame_model[int'(wd.y) * FRAME_DIM + int'(wd.x)] = wd.pixel;
      end
    end else begin
      map_source(wd.x, wd.y, sx, sy);
      if (source_inside(sx, sy)) begin
        r.pixel_out       = frame_model[int'(sy) * FRAME_DIM + int'(sx)];
        r.source_in_range = 1'b1;
      end else begin
        r.pixel_out       = cfg_fill;
        r.source_in_range = 1'b0;
      end
      expected_pixels.push_back(r);
    end
  endtask

  // Input driver: holds a word until it is taken, idles in bursts between words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_word.valid <= 1'b0;
      src_idle_left = 0;
    end else begin
      if (in_word.valid && in_word.ready) begin
        apply_word(offered_word);
      end
      if (!in_word.valid || in_word.ready) begin
        if (src_idle_left != 0) begin
          src_idle_left--;
          in_word.valid <= 1'b0;
        end else if (pending_words.size() != 0 && $urandom_range(99) < src_idle_pct) begin
          src_idle_left = $urandom_range(11);
          in_word.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          offered_word = pending_words.pop_front();
          in_word.valid    <= 1'b1;
          in_word.req_type <= offered_word.kind;
          in_word.coord_x  <= offered_word.x;
          in_word.coord_y  <= offered_word.y;
          in_word.pixel_in <= offered_word.pixel;
        end else begin
          in_word.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started whenever the stimulus toggles its request.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_seen <= 1'b0;
    end else if (stall_request != stall_seen) begin
      stall_left <= HOLD_OFF_CYCLES;
      stall_seen <= stall_request;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result monitor: checks each accepted word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_word.ready <= 1'b0;
      sink_idle_left = 0;
    end else begin
      if (out_word.valid && out_word.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with no query waiting: pixel_out %0h source_in_range %0b",
                 out_word.pixel_out, out_word.source_in_range);
          mismatch_count++;
        end else begin
          oldest_pixel = expected_pixels.pop_front();
          if (out_word.pixel_out !== oldest_pixel.pixel_out) begin
            $error("pixel_out: expected %0h, got %0h",
                   oldest_pixel.pixel_out, out_word.pixel_out);
            mismatch_count++;
          end
          if (out_word.source_in_range !== oldest_pixel.source_in_range) begin
            $error("source_in_range: expected %0b, got %0b",
                   oldest_pixel.source_in_range, out_word.source_in_range);
            mismatch_count++;
          end
        end
      end
      if (stall_left != 0) begin
        out_word.ready <= 1'b0;
      end else if (sink_idle_left != 0) begin
        sink_idle_left--;
        out_word.ready <= 1'b0;
      end else if ($urandom_range(99) < sink_idle_pct) begin
        sink_idle_left = $urandom_range(11);
        out_word.ready <= 1'b0;
      end else begin
        out_word.ready <= 1'b1;
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic apb_write(input cfg_reg_t reg_idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(reg_idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_IMAGE_WIDTH:  cfg_width  = value[DIM_REG_W-1:0];
      REG_IMAGE_HEIGHT: cfg_height = value[DIM_REG_W-1:0];
      REG_ANGLE:        cfg_angle  = value[ANGLE_W-1:0];
      REG_FILL:         cfg_fill   = value[PIXEL_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every word is taken and every result is in, then let loads settle.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_word.valid || expected_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Rewrite all four registers; junk sets the bits above each register's width.
  task automatic configure_image(input int unsigned w, input int unsigned h,
                                 input int unsigned a, input int unsigned f, input bit junk);
    logic [CFG_DATA_W-1:0] hi9;
    logic [CFG_DATA_W-1:0] hi8;
    hi9 = junk ? 32'hFFFF_FE00 : 32'h0;
    hi8 = junk ? 32'hFFFF_FF00 : 32'h0;
    wait_idle();
    apb_write(REG_IMAGE_WIDTH,  hi9 | 32'(w[8:0]));
    apb_write(REG_IMAGE_HEIGHT, hi9 | 32'(h[8:0]));
    apb_write(REG_ANGLE,        hi9 | 32'(a[8:0]));
    apb_write(REG_FILL,         hi8 | 32'(f[7:0]));
  endtask

  task automatic start_phase(input int src_pct, input int sink_pct);
    @(negedge clk);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  task automatic add_load(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                          input logic [PIXEL_W-1:0] p);
    pending_words.push_back('{kind: REQ_LOAD, x: x, y: y, pixel: p});
    if (x < eff_dim(cfg_width) && y < eff_dim(cfg_height)) begin
      pixel_loaded[int'(y) * FRAME_DIM + int'(x)] = 1'b1;
    end
  endtask

  // A query whose source pixel has never been loaded gets that load first.
  task automatic add_query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    longint sx;
    longint sy;
    map_source(x, y, sx, sy);
    if (source_inside(sx, sy) && !pixel_loaded[int'(sy) * FRAME_DIM + int'(sx)]) begin
      add_load(COORD_W'(sx), COORD_W'(sy), PIXEL_W'($urandom));
    end
    pending_words.push_back('{kind: REQ_QUERY, x: x, y: y, pixel: PIXEL_W'($urandom)});
  endtask

  // Random mix of loads and queries; half the queries are aimed into the image.
  task automatic random_burst(input int count);
    int unsigned w;
    int unsigned h;
    int unsigned u;
    int unsigned v;
    int          xi;
    int          yi;
    real         cr;
    real         sr;
    w  = eff_dim(cfg_width);
    h  = eff_dim(cfg_height);
    cr = real'(sine_q14[(reduced_angle() + 90) % 360]) / 16384.0;
    sr = real'(sine_q14[reduced_angle()]) / 16384.0;
    repeat (count) begin
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(9) < 8) begin
          add_load(COORD_W'($urandom_range(w - 1)), COORD_W'($urandom_range(h - 1)),
                   PIXEL_W'($urandom));
        end else begin
          add_load(COORD_W'($urandom), COORD_W'($urandom), PIXEL_W'($urandom));
        end
      end else if ($urandom_range(1) == 0) begin
        add_query(COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        u  = $urandom_range(w - 1);
        v  = $urandom_range(h - 1);
        xi = $rtoi(cr * u - sr * v + 0.5);
        yi = $rtoi(sr * u + cr * v + 0.5);
        if (xi >= 0 && xi < FRAME_DIM && yi >= 0 && yi < FRAME_DIM) begin
          add_query(COORD_W'(xi), COORD_W'(yi));
        end else begin
          add_query(COORD_W'($urandom), COORD_W'($urandom));
        end
      end
    end
  endtask

  // Stimulus: directed cases, random phases over several settings, then the end check.
  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_word.valid    = 1'b0;
    in_word.req_type = REQ_LOAD;
    in_word.coord_x  = '0;
    in_word.coord_y  = '0;
    in_word.pixel_in = '0;
    out_word.ready   = 1'b0;
    stall_request    = 1'b0;
    mismatch_count   = 0;
    src_idle_pct     = 0;
    sink_idle_pct    = 0;
    cfg_width        = DIM_RESET;
    cfg_height       = DIM_RESET;
    cfg_angle        = '0;
    cfg_fill         = '0;
    for (int d = 0; d < 360; d++) sine_q14[d] = signed_sine(d);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: corner pixels with extreme values, no rotation.
    start_phase(30, 30);
    add_load(8'd0,   8'd0,   8'h00);
    add_load(8'd255, 8'd255, 8'hFF);
    add_load(8'd255, 8'd0,   8'h5A);
    add_load(8'd0,   8'd255, 8'hA5);
    add_query(8'd0,   8'd0);
    add_query(8'd255, 8'd255);
    add_query(8'd255, 8'd0);
    add_query(8'd0,   8'd255);

    // Quarter turn: sources above the image give the fill value.
    configure_image(256, 256, 90, 255, 1'b0);
    start_phase(30, 30);
    add_query(8'd0, 8'd0);
    add_query(8'd5, 8'd0);
    add_query(8'd0, 8'd5);
    add_query(8'd255, 8'd255);

    // Diagonal: a source coordinate just below zero truncates to zero.
    configure_image(256, 256, 45, 0, 1'b0);
    start_phase(30, 30);
    add_query(8'd1, 8'd0);
    add_query(8'd0, 8'd1);
    add_query(8'd1, 8'd1);
    add_query(8'd200, 8'd3);

    configure_image(256, 256, 30, 8'h5A, 1'b0);
    start_phase(20, 20);
    random_burst(90);

    // Width of zero acts as one, height above the frame acts as the frame.
    configure_image(0, 511, 359, 255, 1'b1);
    start_phase(20, 0);
    random_burst(70);

    // Angle above a full turn wraps round.
    configure_image(17, 200, 400, 0, 1'b1);
    start_phase(0, 25);
    random_burst(80);

    configure_image(256, 1, 180, 8'h81, 1'b0);
    start_phase(15, 15);
    random_burst(60);

    repeat (3) begin
      configure_image($urandom_range(511), $urandom_range(511), $urandom_range(511),
                      $urandom_range(255), 1'($urandom_range(1)));
      start_phase($urandom_range(30), $urandom_range(30));
      random_burst(70);
    end

    // Receiver holds off while queries keep coming, so the input must stall.
    configure_image(256, 256, 0, 8'h3C, 1'b0);
    start_phase(0, 0);
    stall_request = ~stall_request;
    repeat (60) add_query(COORD_W'($urandom), COORD_W'($urandom));

    // Closing stretch at full rate on both sides.
    configure_image(256, 256, 270, 8'hC3, 1'b0);
    start_phase(0, 0);
    random_burst(100);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[image_rotation_remapper] OK");
    end else begin
      $display("[image_rotation_remapper] ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2ms;
    $display("[image_rotation_remapper] ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/irr_pkg.sv
rtl/core/irr_if.sv
rtl/core/irr_ram.sv
rtl/core/irr_out_fifo.sv
rtl/core/image_rotation_remapper.sv
rtl/core/irr_checker.sv
verif/tb_top.sv
